>>> rtl/core/mtl_pkg.sv
`timescale 1ns / 1ps
package mtl_pkg;

    localparam int CHANNELS        = 5;
    localparam int CH_W            = 3;
    localparam int SINE_TABLE_BITS = 8;
    localparam int QUARTER         = 1 << (SINE_TABLE_BITS - 2);

    localparam logic [31:0] RATE_RESET  = 32'd17179869;
    localparam logic [11:0] SCALE_RESET = 12'd43;
    localparam logic [31:0] SCALE_MAX   = 32'd2048;
    localparam logic [31:0] MOD_MAX     = 32'd16383;

    // command opcodes
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RATE  = 2'd1,
        OP_SCALE = 2'd2,
        OP_MOD   = 2'd3
    } t_op;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_ENABLE = 2'd0,
        REG_SINE   = 2'd1,
        REG_SHARED = 2'd2,
        REG_ACTIVE = 2'd3
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic            load;   // capture command beat
        logic            write;  // apply table write
        logic            ph;     // phase multiply for channel
        logic            prod;   // y * modulation
        logic            fin;    // * scale
        logic            emit;   // drive result
        logic [CH_W-1:0] ch;
        logic            last;
    } t_ctl;

    // quarter-wave sine, Q15, from the Q30 odd polynomial (elaboration only)
    function automatic logic [16:0] quarter_sine(input int k);
        logic [63:0] u, u2, t, s, y;
        u  = 64'(k) << (32 - SINE_TABLE_BITS);
        u2 = (u * u) >> 30;
        t  = 64'd5026995 - ((u2 * 64'd172272) >> 30);
        t  = 64'd85569306 - ((u2 * t) >> 30);
        t  = 64'd693598669 - ((u2 * t) >> 30);
        t  = 64'd1686629713 - ((u2 * t) >> 30);
        s  = (u * t) >> 30;
        y  = (s * 64'd32768 + (64'd1 << 29)) >> 30;
        if (y > 64'd32768) y = 64'd32768;
        return y[16:0];
    endfunction

endpackage

>>> rtl/core/mtl_datapath.sv
`timescale 1ns / 1ps
module mtl_datapath (
    input  logic                  i_clk,
    input  mtl_pkg::t_ctl         i_ctl,
    input  logic [1:0]            i_opcode,
    input  logic [31:0]           i_time_ms,
    input  logic [2:0]            i_target_channel,
    input  logic [31:0]           i_write_value,
    input  logic                  i_rst_n,
    input  logic [4:0]            i_sine_mask,
    input  logic                  i_shared_rate,
    output logic [1:0]            o_op,
    output logic [2:0]            o_channel_index,
    output logic signed [12:0]    o_offset_value,
    output logic                  o_last_of_tick
);
    import mtl_pkg::*;

    logic [31:0] r_rate  [CHANNELS];
    logic [11:0] r_scale [CHANNELS];
    logic [13:0] r_mod   [CHANNELS];
    logic [1:0]  r_op;
    logic [31:0] r_time;
    logic [2:0]  r_tch;
    logic [31:0] r_val;
    logic [31:0] r_phase;
    logic        r_sine;
    logic [30:0] r_prod;
    logic [42:0] r_mag;
    logic        r_neg;
    logic [2:0]  r_och;
    logic        r_last;

    // wave lookup from registered phase
    logic [SINE_TABLE_BITS-1:0] w_idx;
    logic [SINE_TABLE_BITS-3:0] w_k0;
    logic [SINE_TABLE_BITS-2:0] w_k;
    logic [16:0] w_qs;
    logic [16:0] w_tri_mag;
    logic        w_tri_neg;
    logic [16:0] w_mag;
    logic        w_neg;
    logic [16:0] w_p;
    logic [CH_W-1:0] w_wch;

    assign w_idx = r_phase[31 -: SINE_TABLE_BITS];
    assign w_k0  = w_idx[SINE_TABLE_BITS-3:0];
    assign w_k   = w_idx[SINE_TABLE_BITS-2] ?
                   (SINE_TABLE_BITS-1)'(QUARTER) - {1'b0, w_k0} : {1'b0, w_k0};
    assign w_p   = r_phase[31:15];

    always_comb begin
        w_qs = '0;
        for (int j = 0; j <= QUARTER; j++) begin
            if (int'(w_k) == j) w_qs = quarter_sine(j);
        end
        // triangle: p - 32768 rising, 98304 - p falling
        if (!r_phase[31]) begin
            w_tri_neg = !w_p[15];
            w_tri_mag = w_p[15] ? {2'b0, w_p[14:0]} : 17'd32768 - {2'b0, w_p[14:0]};
        end else begin
            w_tri_neg = w_p[15];
            w_tri_mag = w_p[15] ? {2'b0, w_p[14:0]} : 17'd32768 - {2'b0, w_p[14:0]};
        end
        if (r_sine) begin
            w_mag = w_qs;
            w_neg = w_idx[SINE_TABLE_BITS-1];
        end else begin
            w_mag = w_tri_mag;
            w_neg = w_tri_neg;
        end
    end

    assign w_wch = i_shared_rate ? '0 : i_ctl.ch;

    // table writes, tick capture and arithmetic
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < CHANNELS; j++) begin
                r_rate[j]  <= RATE_RESET;
                r_scale[j] <= SCALE_RESET;
                r_mod[j]   <= '0;
            end
        end else if (i_ctl.write && r_tch < 3'(CHANNELS)) begin
            case (t_op'(r_op))
                OP_RATE:  if (r_val != '0) r_rate[r_tch[CH_W-1:0]] <= r_val;
                OP_SCALE: if (r_val <= SCALE_MAX) r_scale[r_tch[CH_W-1:0]] <= r_val[11:0];
                OP_MOD:   r_mod[r_tch[CH_W-1:0]] <= (r_val > MOD_MAX) ? 14'(MOD_MAX) : r_val[13:0];
                default:  ;
            endcase
        end
        if (i_ctl.load) begin
            r_op   <= i_opcode;
            r_time <= i_time_ms;
            r_tch  <= i_target_channel;
            r_val  <= i_write_value;
        end
        if (i_ctl.ph) begin
            r_phase <= r_time * r_rate[w_wch];
            r_sine  <= i_sine_mask[w_wch];
        end
        if (i_ctl.prod) begin
            r_prod <= 31'(w_mag) * 31'(r_mod[i_ctl.ch]);
            r_neg  <= w_neg;
        end
        if (i_ctl.fin) begin
            r_mag  <= 43'(r_prod) * 43'(r_scale[i_ctl.ch]);
            r_och  <= i_ctl.ch;
            r_last <= i_ctl.last;
        end
    end

    logic [12:0] w_m;
    assign w_m             = r_mag[41:29];
    assign o_op            = r_op;
    assign o_channel_index = r_och;
    assign o_offset_value  = r_neg ? -$signed(w_m) : $signed(w_m);
    assign o_last_of_tick  = r_last;
endmodule

>>> rtl/core/mtl_ctrl.sv
`timescale 1ns / 1ps
module mtl_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_op,
    input  logic [4:0]          i_enable_mask,
    input  logic [2:0]          i_active_count,
    output logic                o_busy,
    output logic                o_strobe,
    output mtl_pkg::t_ctl       o_ctl
);
    import mtl_pkg::*;

    t_state          r_state, n_state;
    logic [CH_W-1:0] r_ch, n_ch;
    logic            w_en;
    logic            w_more;
    logic [2:0]      w_lim;

    assign w_lim = (i_active_count > 3'(CHANNELS)) ? 3'(CHANNELS) : i_active_count;
    assign w_en  = (3'(r_ch) < w_lim) && i_enable_mask[r_ch];

    // any enabled channel above the current one within the active count
    always_comb begin
        w_more = 1'b0;
        for (int j = 0; j < CHANNELS; j++) begin
            if (j > int'(r_ch) && 3'(j) < w_lim && i_enable_mask[j]) w_more = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_ch      = r_ch;
        o_ctl     = '0;
        o_ctl.ch  = r_ch;
        o_ctl.last = !w_more;
        o_busy    = (r_state != ST_IDLE);
        o_strobe  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ctl.load = i_start;
                if (i_start) begin
                    n_state = ST_SCAN;
                    n_ch    = '0;
                end
            end
            ST_SCAN: begin
                if (t_op'(i_op) != OP_TICK) begin
                    o_ctl.write = 1'b1;
                    n_state     = ST_IDLE;
                end else if (3'(r_ch) >= w_lim || 32'(r_ch) >= 32'(CHANNELS - 1) && !w_en) begin
                    n_state = ST_IDLE;
                end else if (w_en) begin
                    o_ctl.ph = 1'b1;
                    n_state  = ST_MUL1;
                end else begin
                    n_ch = r_ch + 1'b1;
                end
            end
            ST_MUL1: begin
                o_ctl.prod = 1'b1;
                n_state    = ST_MUL2;
            end
            ST_MUL2: begin
                o_ctl.fin = 1'b1;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                o_strobe = 1'b1;
                if (!w_more || 32'(r_ch) >= 32'(CHANNELS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_ch    = r_ch + 1'b1;
                    n_state = ST_SCAN;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

>>> rtl/core/multichannel_tremolo_lfo.sv
`timescale 1ns / 1ps
// a write command loads its beat at start and applies the table write while scanning
// a tick scans the channels in order, skipping disabled ones; each emitted
// offset passes through phase multiply, modulation, scale and output beat
// offsets strobe in their output beat, in ascending channel order
// the receiver cannot stall; each offset is valid for one cycle on o_strobe
// synchronous active-low reset restores config, FSM and channel tables to defaults
module multichannel_tremolo_lfo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_opcode,
    input  logic [31:0]        i_time_ms,
    input  logic [2:0]         i_target_channel,
    input  logic [31:0]        i_write_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_strobe,
    output logic [2:0]         o_channel_index,
    output logic signed [12:0] o_offset_value,
    output logic               o_last_of_tick
);
    import mtl_pkg::*;

    logic [4:0] r_enable;
    logic [4:0] r_sine;
    logic       r_shared;
    logic [2:0] r_active;
    t_ctl       w_ctl;
    logic [1:0] w_op;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= '0;
            r_sine   <= 5'd31;
            r_shared <= 1'b0;
            r_active <= 3'd5;
        end else if (i_cfg_valid) begin
            unique case (t_reg'(i_cfg_index))
                REG_ENABLE: r_enable <= i_cfg_data[4:0];
                REG_SINE:   r_sine   <= i_cfg_data[4:0];
                REG_SHARED: r_shared <= i_cfg_data[0];
                REG_ACTIVE: r_active <= i_cfg_data[2:0];
                default:    ;
            endcase
        end
    end

    mtl_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_op           (w_op),
        .i_enable_mask  (r_enable),
        .i_active_count (r_active),
        .o_busy         (busy),
        .o_strobe       (o_strobe),
        .o_ctl          (w_ctl)
    );

    mtl_datapath u_dp (
        .i_clk            (i_clk),
        .i_ctl            (w_ctl),
        .i_opcode         (i_opcode),
        .i_time_ms        (i_time_ms),
        .i_target_channel (i_target_channel),
        .i_write_value    (i_write_value),
        .i_rst_n          (i_rst_n),
        .i_sine_mask      (r_sine),
        .i_shared_rate    (r_shared),
        .o_op             (w_op),
        .o_channel_index  (o_channel_index),
        .o_offset_value   (o_offset_value),
        .o_last_of_tick   (o_last_of_tick)
    );
endmodule
